[hw/rtl/flia_pkg.sv]
// flia_pkg: shared codes for the free-list index allocator
// request kinds, result status codes and controller states
// no dependencies
`default_nettype none

package flia_pkg;

  // request kind of one transaction
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // controller state
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // tag field width is fixed by the interface
  localparam int unsigned TagW = 32;

endpackage

`default_nettype wire

[hw/rtl/free_list_index_allocator_unit.sv]
// Free-list index allocator: hands out table indexes, recycling freed ones LIFO.
// Result strobe done_o is registered: it rises at the edge that ends the execute step.
// Takes no new transaction while busy; busy covers the ram read-then-write step.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (async, active low) empties the recycle stack and reserves index 0; no ram clear.
// Depends on flia_pkg, flia_ram, flia_ctrl.
`default_nettype none

module free_list_index_allocator_unit #(
  parameter int unsigned ENTRIES   = 1024,
  parameter int unsigned KIND_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 kind_i,
  input  wire logic [$clog2(ENTRIES)-1:0] entry_index_i,
  input  wire logic [KIND_BITS-1:0]       entry_kind_i,
  input  wire logic [flia_pkg::TagW-1:0]  entry_tag_i,
  output logic                            done_o,
  output logic      [$clog2(ENTRIES)-1:0] result_index_o,
  output logic      [KIND_BITS-1:0]       kind_out_o,
  output logic      [flia_pkg::TagW-1:0]  tag_out_o,
  output logic      [1:0]                 status_o
);

  import flia_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned TblW = KIND_BITS + TagW;

  logic            stk_re, stk_we;
  logic [IdxW-1:0] stk_raddr, stk_rdata, stk_waddr, stk_wdata;

  logic                 tbl_re, tbl_we;
  logic [IdxW-1:0]      tbl_raddr, tbl_waddr;
  logic [KIND_BITS-1:0] tbl_wkind;
  logic [TagW-1:0]      tbl_wtag;
  logic [TblW-1:0]      tbl_rdata;

  // sequencer and result register
  flia_ctrl #(
    .ENTRIES  (ENTRIES),
    .KIND_BITS(KIND_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_kind_i  (entry_kind_i),
    .entry_tag_i   (entry_tag_i),
    .stk_re_o      (stk_re),
    .stk_raddr_o   (stk_raddr),
    .stk_rdata_i   (stk_rdata),
    .stk_we_o      (stk_we),
    .stk_waddr_o   (stk_waddr),
    .stk_wdata_o   (stk_wdata),
    .tbl_re_o      (tbl_re),
    .tbl_raddr_o   (tbl_raddr),
    .tbl_rkind_i   (tbl_rdata[TblW-1:TagW]),
    .tbl_rtag_i    (tbl_rdata[TagW-1:0]),
    .tbl_we_o      (tbl_we),
    .tbl_waddr_o   (tbl_waddr),
    .tbl_wkind_o   (tbl_wkind),
    .tbl_wtag_o    (tbl_wtag),
    .done_o        (done_o),
    .result_index_o(result_index_o),
    .kind_out_o    (kind_out_o),
    .tag_out_o     (tag_out_o),
    .status_o      (status_o)
  );

  // recycle stack of freed indexes
  flia_ram #(
    .Width(IdxW),
    .Depth(ENTRIES)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // entry table, kind and tag side by side
  flia_ram #(
    .Width(TblW),
    .Depth(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i({tbl_wkind, tbl_wtag}),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

endmodule

`default_nettype wire

[hw/rtl/flia_ram.sv]
// flia_ram: single-clock ram, one write port and one registered read port
// read data is registered, valid in the cycle after the read enable; contents undefined until written
// no dependencies
`default_nettype none

module flia_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/flia_ctrl.sv]
// flia_ctrl: request sequencer, stack pointer, fresh-index counter and result register
// drives the read and write ports of the recycle stack ram and the entry table ram
// depends on flia_pkg
`default_nettype none

module flia_ctrl #(
  parameter int unsigned ENTRIES   = 1024,
  parameter int unsigned KIND_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request side
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 kind_i,
  input  wire logic [$clog2(ENTRIES)-1:0] entry_index_i,
  input  wire logic [KIND_BITS-1:0]       entry_kind_i,
  input  wire logic [flia_pkg::TagW-1:0]  entry_tag_i,
  // recycle stack ram
  output logic                            stk_re_o,
  output logic      [$clog2(ENTRIES)-1:0] stk_raddr_o,
  input  wire logic [$clog2(ENTRIES)-1:0] stk_rdata_i,
  output logic                            stk_we_o,
  output logic      [$clog2(ENTRIES)-1:0] stk_waddr_o,
  output logic      [$clog2(ENTRIES)-1:0] stk_wdata_o,
  // entry table ram
  output logic                            tbl_re_o,
  output logic      [$clog2(ENTRIES)-1:0] tbl_raddr_o,
  input  wire logic [KIND_BITS-1:0]       tbl_rkind_i,
  input  wire logic [flia_pkg::TagW-1:0]  tbl_rtag_i,
  output logic                            tbl_we_o,
  output logic      [$clog2(ENTRIES)-1:0] tbl_waddr_o,
  output logic      [KIND_BITS-1:0]       tbl_wkind_o,
  output logic      [flia_pkg::TagW-1:0]  tbl_wtag_o,
  // result side
  output logic                            done_o,
  output logic      [$clog2(ENTRIES)-1:0] result_index_o,
  output logic      [KIND_BITS-1:0]       kind_out_o,
  output logic      [flia_pkg::TagW-1:0]  tag_out_o,
  output logic      [1:0]                 status_o
);

  import flia_pkg::*;

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [IdxW:0] EntriesW = (IdxW+1)'(ENTRIES);
  localparam logic [IdxW:0] OneW     = (IdxW+1)'(1);

  state_e state_q, state_d;
  logic   accept;

  // captured request
  op_e                 op_q;
  logic [IdxW-1:0]     idx_q;
  logic [KIND_BITS-1:0] kind_q;
  logic [TagW-1:0]     tag_q;

  // allocator state
  logic [IdxW:0] top_q, top_d;
  logic [IdxW:0] fresh_q, fresh_d;
  logic          entry0_wr_q, entry0_wr_d;
  logic [IdxW:0] top_dec;

  // result register
  logic                 done_q;
  logic [IdxW-1:0]      res_idx_q, res_idx_d;
  logic [KIND_BITS-1:0] res_kind_q, res_kind_d;
  logic [TagW-1:0]      res_tag_q, res_tag_d;
  status_e              res_st_q, res_st_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state outputs and ram read ports, reads issued with the accepting edge
  always_comb begin
    busy        = (state_q == S_EXEC);
    accept      = start && (state_q == S_IDLE);
    top_dec     = top_q - OneW;
    stk_re_o    = accept;
    stk_raddr_o = top_dec[IdxW-1:0];
    tbl_re_o    = accept;
    tbl_raddr_o = entry_index_i;
  end

  // execute step: read data is back, decide, write rams and pointers
  always_comb begin
    top_d       = top_q;
    fresh_d     = fresh_q;
    entry0_wr_d = entry0_wr_q;
    stk_we_o    = 1'b0;
    stk_waddr_o = top_q[IdxW-1:0];
    stk_wdata_o = idx_q;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = stk_rdata_i;
    tbl_wkind_o = kind_q;
    tbl_wtag_o  = tag_q;
    res_idx_d   = idx_q;
    res_kind_d  = '0;
    res_tag_d   = '0;
    res_st_d    = ST_OK;
    if (state_q == S_EXEC) begin
      case (op_q)
        OP_ALLOC: begin
          if (top_q != '0) begin
            top_d    = top_dec;
            tbl_we_o = 1'b1;
          end else if (fresh_q < EntriesW) begin
            tbl_waddr_o = fresh_q[IdxW-1:0];
            fresh_d     = fresh_q + OneW;
            tbl_we_o    = 1'b1;
          end
          if (tbl_we_o) begin
            res_idx_d  = tbl_waddr_o;
            res_kind_d = kind_q;
            res_tag_d  = tag_q;
            if (tbl_waddr_o == '0) begin
              entry0_wr_d = 1'b1;
            end
          end else begin
            res_idx_d = '0;
            res_st_d  = ST_EXHAUSTED;
          end
        end
        OP_FREE: begin
          if ({1'b0, idx_q} >= EntriesW) begin
            res_st_d = ST_RANGE;
          end else if (top_q >= EntriesW) begin
            res_st_d = ST_FULL;
          end else begin
            stk_we_o = 1'b1;
            top_d    = top_q + OneW;
          end
        end
        OP_LOOKUP: begin
          if (({1'b0, idx_q} >= fresh_q) || ({1'b0, idx_q} >= EntriesW)) begin
            res_st_d = ST_RANGE;
          end else if ((idx_q != '0) || entry0_wr_q) begin
            // the reserved entry reads as zero until something is stored there
            res_kind_d = tbl_rkind_i;
            res_tag_d  = tbl_rtag_i;
          end
        end
        default: begin
          res_idx_d = '0;
          res_st_d  = ST_RANGE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      fresh_q     <= OneW;
      entry0_wr_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      fresh_q     <= fresh_d;
      entry0_wr_q <= entry0_wr_d;
      done_q      <= (state_q == S_EXEC);
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(kind_i);
      idx_q  <= entry_index_i;
      kind_q <= entry_kind_i;
      tag_q  <= entry_tag_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      res_idx_q  <= res_idx_d;
      res_kind_q <= res_kind_d;
      res_tag_q  <= res_tag_d;
      res_st_q   <= res_st_d;
    end
  end

  assign done_o         = done_q;
  assign result_index_o = res_idx_q;
  assign kind_out_o     = res_kind_q;
  assign tag_out_o      = res_tag_q;
  assign status_o       = res_st_q;

`ifndef SYNTHESIS
  // every accepted transaction is followed by a result strobe once its execute step ends
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_q)
    else $error("accepted transaction gave no result");

  // no result strobe while a transaction is executing
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe overlaps execute step");

  // pointers stay inside the table
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q <= EntriesW) && (fresh_q <= EntriesW) && (fresh_q != '0))
    else $error("stack top or fresh index out of range");

  // a ram write only happens in the execute step, one ram at a time
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stk_we_o || tbl_we_o) |-> ((state_q == S_EXEC) && !(stk_we_o && tbl_we_o)))
    else $error("ram write outside execute step");

  // the stack top holds while idle; pop and push move it only from the execute step
  a_top_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(top_q) || (state_q == S_EXEC))
    else $error("stack top moved while idle");
`endif

endmodule

`default_nettype wire

[test/free_list_checker.sv]
// free_list_checker: predicts and checks every result of the index allocator
// keeps its own copy of the recycle stack, fresh counter and entry tables
// depends on flia_pkg
module free_list_checker
  import flia_pkg::*;
#(
  parameter int unsigned ENTRIES   = 1024,
  parameter int unsigned KIND_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       busy_i,
  input  wire logic [1:0]                 kind_i,
  input  wire logic [$clog2(ENTRIES)-1:0] entry_index_i,
  input  wire logic [KIND_BITS-1:0]       entry_kind_i,
  input  wire logic [TagW-1:0]            entry_tag_i,
  input  wire logic                       done_i,
  input  wire logic [$clog2(ENTRIES)-1:0] result_index_i,
  input  wire logic [KIND_BITS-1:0]       kind_out_i,
  input  wire logic [TagW-1:0]            tag_out_i,
  input  wire logic [1:0]                 status_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned PrintCap = 20;

  // one expected allocator reply
  typedef struct packed {
    logic [IdxW-1:0]      index;
    logic [KIND_BITS-1:0] kind;
    logic [TagW-1:0]      tag;
    status_e              status;
  } alloc_reply_t;

  // shadow allocator state
  logic [IdxW-1:0]      recycle_mem [ENTRIES];
  logic [KIND_BITS-1:0] kind_mem    [ENTRIES];
  logic [TagW-1:0]      tag_mem     [ENTRIES];
  int unsigned          recycle_depth;
  int unsigned          fresh_index;
  alloc_reply_t         reply_q [$];
  int unsigned          mismatches = 0;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // apply one transaction to the shadow state and return its reply
  function automatic alloc_reply_t predict_reply(op_e op, logic [IdxW-1:0] idx,
                                                 logic [KIND_BITS-1:0] knd,
                                                 logic [TagW-1:0] tag);
    alloc_reply_t r;
    int unsigned  slot;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (recycle_depth > 0) begin
          recycle_depth--;
          slot = recycle_mem[recycle_depth];
        end else if (fresh_index < ENTRIES) begin
          slot = fresh_index;
          fresh_index++;
        end else begin
          r.status = ST_EXHAUSTED;
          return r;
        end
        kind_mem[slot] = knd;
        tag_mem[slot]  = tag;
        r.index = IdxW'(slot);
        r.kind  = knd;
        r.tag   = tag;
      end
      OP_FREE: begin
        r.index = idx;
        if (idx >= ENTRIES) begin
          r.status = ST_RANGE;
        end else if (recycle_depth >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          recycle_mem[recycle_depth] = idx;
          recycle_depth++;
        end
      end
      OP_LOOKUP: begin
        r.index = idx;
        if (idx >= fresh_index || idx >= ENTRIES) begin
          r.status = ST_RANGE;
        end else begin
          r.kind = kind_mem[idx];
          r.tag  = tag_mem[idx];
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    return r;
  endfunction

  // compare results, then record newly accepted transactions
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t want;
    if (!rst_ni) begin
      recycle_depth = 0;
      fresh_index   = 1;
      kind_mem[0]   = '0;
      tag_mem[0]    = '0;
      reply_q.delete();
      pending_o    <= 0;
      mismatches_o <= mismatches;
    end else begin
      if (done_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with nothing pending, index", result_index_i, 0);
        end else begin
          want = reply_q.pop_front();
          if (result_index_i !== want.index) begin
            report_mismatch("result_index", result_index_i, want.index);
          end
          if (kind_out_i !== want.kind) begin
            report_mismatch("kind_out", kind_out_i, want.kind);
          end
          if (tag_out_i !== want.tag) begin
            report_mismatch("tag_out", tag_out_i, want.tag);
          end
          if (status_i !== want.status) begin
            report_mismatch("status", status_i, want.status);
          end
        end
      end
      if (start_i && !busy_i) begin
        reply_q.push_back(predict_reply(op_e'(kind_i), entry_index_i, entry_kind_i,
                                        entry_tag_i));
      end
      pending_o    <= reply_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

[test/tb_free_list_index_allocator_unit.sv]
// tb_free_list_index_allocator_unit: stimulus and verdict for the index allocator
// directed corner transactions, then random phases that exhaust the table and recycle indexes
// depends on flia_pkg, free_list_index_allocator_unit and free_list_checker
module tb_free_list_index_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import flia_pkg::*;

  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned KIND_BITS  = 8;
  localparam int unsigned IdxW       = $clog2(ENTRIES);
  localparam int unsigned QuietLimit = 400;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start;
  logic                 busy;
  logic [1:0]           req_kind;
  logic [IdxW-1:0]      req_index;
  logic [KIND_BITS-1:0] req_entry_kind;
  logic [TagW-1:0]      req_tag;
  logic                 done;
  logic [IdxW-1:0]      rsp_index;
  logic [KIND_BITS-1:0] rsp_kind;
  logic [TagW-1:0]      rsp_tag;
  logic [1:0]           rsp_status;
  int unsigned          mismatches;
  int unsigned          pending;

  // coarse allocator occupancy, used only to steer the stimulus, and tallies for the summary
  int unsigned stack_depth  = 0;
  int unsigned fresh_next   = 1;
  int unsigned burst_left   = 0;
  int unsigned sent_count   [4] = '{default: 0};
  int unsigned status_count [4] = '{default: 0};

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  free_list_index_allocator_unit #(
    .ENTRIES  (ENTRIES),
    .KIND_BITS(KIND_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (req_kind),
    .entry_index_i (req_index),
    .entry_kind_i  (req_entry_kind),
    .entry_tag_i   (req_tag),
    .done_o        (done),
    .result_index_o(rsp_index),
    .kind_out_o    (rsp_kind),
    .tag_out_o     (rsp_tag),
    .status_o      (rsp_status)
  );

  free_list_checker #(
    .ENTRIES  (ENTRIES),
    .KIND_BITS(KIND_BITS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .kind_i        (req_kind),
    .entry_index_i (req_index),
    .entry_kind_i  (req_entry_kind),
    .entry_tag_i   (req_tag),
    .done_i        (done),
    .result_index_i(rsp_index),
    .kind_out_i    (rsp_kind),
    .tag_out_i     (rsp_tag),
    .status_i      (rsp_status),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // tally of result status codes for the summary
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      status_count[rsp_status]++;
    end
  end

  // idle gap before each transaction, with occasional back-to-back bursts
  function automatic int unsigned draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // index below the fresh boundary: handed out at least once, or the reserved index 0
  function automatic logic [IdxW-1:0] live_index();
    return IdxW'($urandom_range(0, fresh_next - 1));
  endfunction

  // send one transaction and wait until it is accepted
  task automatic issue(op_e op, logic [IdxW-1:0] idx, logic [KIND_BITS-1:0] knd,
                       logic [TagW-1:0] tag);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    req_kind       <= op;
    req_index      <= idx;
    req_entry_kind <= knd;
    req_tag        <= tag;
    do @(posedge clk_i); while (busy);
    case (op)
      OP_ALLOC: begin
        if (stack_depth > 0) begin
          stack_depth--;
        end else if (fresh_next < ENTRIES) begin
          fresh_next++;
        end
      end
      OP_FREE: begin
        if (stack_depth < ENTRIES) begin
          stack_depth++;
        end
      end
      default: ;
    endcase
    sent_count[op]++;
  endtask

  // one random transaction; what is left after alloc and free weights is mostly lookups
  task automatic random_request(int unsigned w_alloc, int unsigned w_free);
    int unsigned     roll;
    logic [IdxW-1:0] idx;
    roll = $urandom_range(0, 99);
    idx  = IdxW'($urandom);
    if (roll < w_alloc) begin
      issue(OP_ALLOC, idx, KIND_BITS'($urandom), TagW'($urandom));
    end else if (roll < w_alloc + w_free) begin
      if ($urandom_range(0, 3) != 0) begin
        idx = live_index();
      end
      issue(OP_FREE, idx, KIND_BITS'($urandom), TagW'($urandom));
    end else if (roll < 97) begin
      if ($urandom_range(0, 4) != 0) begin
        idx = live_index();
      end
      issue(OP_LOOKUP, idx, KIND_BITS'($urandom), TagW'($urandom));
    end else begin
      issue(OP_BAD, idx, KIND_BITS'($urandom), TagW'($urandom));
    end
  endtask

  // cycles with no accepted transaction and no result end the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("free_list_index_allocator_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    start          <= 1'b0;
    req_kind       <= OP_ALLOC;
    req_index      <= '0;
    req_entry_kind <= '0;
    req_tag        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, field extremes, reserved index, double free
    issue(OP_LOOKUP, IdxW'(1), '0, '0);
    issue(OP_ALLOC, '0, '0, '0);
    issue(OP_ALLOC, '1, '1, '1);
    issue(OP_LOOKUP, IdxW'(1), '0, '0);
    issue(OP_LOOKUP, IdxW'(2), '1, '1);
    issue(OP_FREE, '0, '0, '0);
    issue(OP_ALLOC, '0, KIND_BITS'(8'h5a), TagW'(32'h0123_4567));
    issue(OP_LOOKUP, '0, '0, '0);
    issue(OP_FREE, IdxW'(2), '0, '0);
    issue(OP_FREE, IdxW'(2), '0, '0);
    issue(OP_ALLOC, IdxW'(7), KIND_BITS'(8'h81), TagW'(32'h8000_0001));
    issue(OP_ALLOC, IdxW'(9), KIND_BITS'(8'h7e), TagW'(32'h7fff_fffe));
    issue(OP_ALLOC, '1, KIND_BITS'(8'h33), TagW'(32'hdead_beef));
    // lookup at the fresh boundary and far beyond it
    issue(OP_LOOKUP, IdxW'(3), '0, '0);
    issue(OP_LOOKUP, IdxW'(4), '0, '0);
    issue(OP_LOOKUP, '1, '0, '0);
    // highest index freed before it was ever handed out, then recycled
    issue(OP_FREE, '1, '1, '1);
    issue(OP_ALLOC, '0, KIND_BITS'(8'hc3), TagW'(32'h5555_aaaa));
    issue(OP_LOOKUP, '1, '0, '0);
    // freed entry keeps its last contents
    issue(OP_FREE, IdxW'(1), '0, '0);
    issue(OP_LOOKUP, IdxW'(1), '0, '0);
    // unknown request kind
    issue(OP_BAD, '1, '1, '1);
    issue(OP_BAD, '0, '0, '0);

    // mixed traffic
    repeat (120) random_request(40, 27);
    // drain the stack and use up every fresh index
    while (!(stack_depth == 0 && fresh_next == ENTRIES)) random_request(95, 0);
    repeat (4) issue(OP_ALLOC, IdxW'($urandom), KIND_BITS'($urandom), TagW'($urandom));
    issue(OP_LOOKUP, '1, '0, '0);
    // recycle traffic on a fully handed out table
    repeat (60) random_request(30, 50);
    start <= 1'b0;

    // wait for every outstanding result before the summary
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("sent %0d transactions: %0d allocate, %0d free, %0d lookup, %0d unknown kind",
             sent_count[OP_ALLOC] + sent_count[OP_FREE] + sent_count[OP_LOOKUP] +
             sent_count[OP_BAD], sent_count[OP_ALLOC], sent_count[OP_FREE],
             sent_count[OP_LOOKUP], sent_count[OP_BAD]);
    $display("results: %0d ok, %0d table exhausted, %0d out of range, %0d stack full",
             status_count[ST_OK], status_count[ST_EXHAUSTED], status_count[ST_RANGE],
             status_count[ST_FULL]);
    if (mismatches == 0) begin
      $display("free_list_index_allocator_unit verification clean");
    end else begin
      $display("free_list_index_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
